// ----- src/hfsl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the slew-limited heading follower.
// No dependencies; every other file of the block but hfsl_stream_if imports this package.

package hfsl_pkg;

  // Iteration count and table size
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ATAN_LEN     = 24;

  // Datapath widths
  localparam int unsigned CoordW = 16;  // pixel coordinates and config words
  localparam int unsigned ElapsedW = 20;
  localparam int unsigned AngleW = 16;  // binary angle, full turn = 2^16
  localparam int unsigned FineW = 24;   // fine angle, full turn = 2^24
  localparam int unsigned CordicW = 28; // x/y working width incl. CORDIC gain
  localparam int unsigned LimitW = 20;  // (rate * elapsed) >> 16
  localparam int unsigned ProdW = CoordW + ElapsedW;
  localparam int unsigned FracShift = 8; // coordinates scaled by 256 for CORDIC

  localparam logic [FineW-1:0] HALF_TURN_FINE = 24'h80_0000;
  localparam logic [FineW-1:0] BEARING_ROUND  = 24'd128;

  // Register reset values
  localparam logic [CoordW-1:0] PIVOT_X_RST   = 16'd400;
  localparam logic [CoordW-1:0] PIVOT_Y_RST   = 16'd300;
  localparam logic [CoordW-1:0] TURN_RATE_RST = 16'd179;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_PIVOT_X   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PIVOT_Y   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TURN_RATE = 2'd2;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } turn_dir_e;

  typedef struct packed {
    logic signed [CoordW-1:0] target_x;
    logic signed [CoordW-1:0] target_y;
    logic [ElapsedW-1:0]      elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic [AngleW-1:0] heading;
    logic [AngleW-1:0] bearing;
    turn_dir_e         turn_dir;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CoordW-1:0]  data;
  } cfg_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pivot_x;
    logic signed [CoordW-1:0] pivot_y;
    logic [CoordW-1:0]        turn_rate;
  } cfg_regs_t;

  // Data carried down the CORDIC pipeline
  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic [FineW-1:0]          z;
    logic                      at_pivot;
    logic [LimitW-1:0]         limit;
  } cordic_t;

  // atan(2^-i) in 2^-8 binary angle units, rounded to nearest
  function automatic logic [FineW-1:0] atan_fine(input int unsigned idx);
    logic [FineW-1:0] val;
    case (idx)
      0:  val = 24'd2097152;
      1:  val = 24'd1238021;
      2:  val = 24'd654136;
      3:  val = 24'd332050;
      4:  val = 24'd166669;
      5:  val = 24'd83416;
      6:  val = 24'd41718;
      7:  val = 24'd20860;
      8:  val = 24'd10430;
      9:  val = 24'd5215;
      10: val = 24'd2608;
      11: val = 24'd1304;
      12: val = 24'd652;
      13: val = 24'd326;
      14: val = 24'd163;
      15: val = 24'd81;
      16: val = 24'd41;
      17: val = 24'd20;
      18: val = 24'd10;
      19: val = 24'd5;
      20: val = 24'd3;
      21: val = 24'd1;
      22: val = 24'd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ----- src/hfsl_stream_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload word per transaction.
// Standalone; the payload type is supplied by the instantiating scope.

interface hfsl_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/hfsl_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file: pivot position and turn rate.
// Depends on hfsl_pkg and hfsl_stream_if.

module hfsl_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  hfsl_stream_if.sink       cfg_i,
  output hfsl_pkg::cfg_regs_t regs_o
);
  import hfsl_pkg::*;

  cfg_regs_t regs_q;

  // Writes are always taken; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.pivot_x   <= PIVOT_X_RST;
      regs_q.pivot_y   <= PIVOT_Y_RST;
      regs_q.turn_rate <= TURN_RATE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        CFG_PIVOT_X:   regs_q.pivot_x   <= cfg_i.payload.data;
        CFG_PIVOT_Y:   regs_q.pivot_y   <= cfg_i.payload.data;
        CFG_TURN_RATE: regs_q.turn_rate <= cfg_i.payload.data;
        default: ;
      endcase
    end
  end

  assign regs_o = regs_q;

endmodule

// ----- src/hfsl_prep.sv -----
`timescale 1ns / 1ps
// Input register: pivot offset, scaling, left-half-plane pre-rotation, step limit product.
// Depends on hfsl_pkg and hfsl_stream_if.

module hfsl_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  hfsl_stream_if.sink         in_i,
  input  hfsl_pkg::cfg_regs_t cfg_i,
  input  logic                ready_next_i,
  output logic                valid_o,
  output hfsl_pkg::cordic_t   data_o
);
  import hfsl_pkg::*;

  logic                      valid_q;
  cordic_t                   data_q;
  cordic_t                   data_d;
  logic                      ready;
  logic signed [CoordW:0]    dx;
  logic signed [CoordW:0]    dy;
  logic signed [CordicW-1:0] x_scaled;
  logic signed [CordicW-1:0] y_scaled;
  logic [ProdW-1:0]          prod;

  assign ready      = !valid_q || ready_next_i;
  assign in_i.ready = ready;

  // Offset from pivot, scaled by 256, turned by a half turn when left of it
  always_comb begin
    dx = {in_i.payload.target_x[CoordW-1], in_i.payload.target_x}
       - {cfg_i.pivot_x[CoordW-1], cfg_i.pivot_x};
    dy = {in_i.payload.target_y[CoordW-1], in_i.payload.target_y}
       - {cfg_i.pivot_y[CoordW-1], cfg_i.pivot_y};
    x_scaled = CordicW'(dx) <<< FracShift;
    y_scaled = CordicW'(dy) <<< FracShift;
    prod = ProdW'(cfg_i.turn_rate) * ProdW'(in_i.payload.elapsed_us);

    data_d.at_pivot = (dx == '0) && (dy == '0);
    data_d.limit    = prod[ProdW-1 -: LimitW];
    if (dx[CoordW]) begin
      data_d.x = -x_scaled;
      data_d.y = -y_scaled;
      data_d.z = HALF_TURN_FINE;
    end else begin
      data_d.x = x_scaled;
      data_d.y = y_scaled;
      data_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_i.valid) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- src/hfsl_cordic_stage.sv -----
`timescale 1ns / 1ps
// One registered CORDIC vectoring iteration with its own valid bit.
// Depends on hfsl_pkg.

module hfsl_cordic_stage #(
  parameter int unsigned StageIdx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  hfsl_pkg::cordic_t data_i,
  output logic              ready_o,
  input  logic              ready_next_i,
  output logic              valid_o,
  output hfsl_pkg::cordic_t data_o
);
  import hfsl_pkg::*;

  logic    valid_q;
  cordic_t data_q;
  cordic_t data_d;
  logic    rot_pos;

  assign ready_o = !valid_q || ready_next_i;

  // Drive y towards zero; floor shifts throughout
  always_comb begin
    rot_pos = !data_i.y[CordicW-1] && (data_i.y != '0);
    data_d  = data_i;
    if (rot_pos) begin
      data_d.x = data_i.x + (data_i.y >>> StageIdx);
      data_d.y = data_i.y - (data_i.x >>> StageIdx);
      data_d.z = data_i.z + atan_fine(StageIdx);
    end else begin
      data_d.x = data_i.x - (data_i.y >>> StageIdx);
      data_d.y = data_i.y + (data_i.x >>> StageIdx);
      data_d.z = data_i.z - atan_fine(StageIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- src/hfsl_heading.sv -----
`timescale 1ns / 1ps
// Bearing rounding stage, heading state with slew-limited update, and output register.
// Depends on hfsl_pkg and hfsl_stream_if.

module hfsl_heading (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  hfsl_pkg::cordic_t data_i,
  output logic              ready_o,
  hfsl_stream_if.source     out_o
);
  import hfsl_pkg::*;

  logic                  brg_valid_q;
  logic [AngleW-1:0]     brg_q;
  logic [LimitW-1:0]     limit_q;
  logic [FineW-1:0]      z_rounded;
  logic [AngleW-1:0]     brg_d;

  logic                  out_valid_q;
  out_item_t             out_q;
  logic [AngleW-1:0]     heading_q;
  logic [AngleW-1:0]     heading_d;
  turn_dir_e             dir_d;
  logic                  out_ready;

  logic signed [AngleW:0] diff;
  logic [AngleW:0]        diff_abs;
  logic [AngleW-1:0]      mag;
  logic [AngleW-1:0]      step;
  logic                   turn_pos;

  assign out_ready = !out_valid_q || out_o.ready;
  assign ready_o   = !brg_valid_q || out_ready;

  // Fine angle to binary angle, round half up; target at pivot reads as zero
  always_comb begin
    z_rounded = data_i.z + BEARING_ROUND;
    brg_d     = data_i.at_pivot ? '0 : z_rounded[FineW-1 -: AngleW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brg_valid_q <= 1'b0;
    end else if (ready_o) begin
      brg_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      brg_q   <= brg_d;
      limit_q <= data_i.limit;
    end
  end

  // Raw difference, step clamp and shortest-way direction (half turn ties as noted)
  always_comb begin
    diff     = $signed({1'b0, brg_q}) - $signed({1'b0, heading_q});
    diff_abs = diff[AngleW] ? 17'(-diff) : 17'(diff);
    mag      = diff_abs[AngleW-1:0];
    step     = ({{(LimitW-AngleW){1'b0}}, mag} < limit_q) ? mag : limit_q[AngleW-1:0];
    // positive for 0 < d <= half turn, or d below minus half turn
    if (diff > 0) begin
      turn_pos = (diff <= 17'sd32768);
    end else begin
      turn_pos = (diff < -17'sd32768);
    end
    heading_d = heading_q;
    dir_d     = DIR_NONE;
    if ((diff != '0) && (step != '0)) begin
      if (turn_pos) begin
        heading_d = heading_q + step;
        dir_d     = DIR_POS;
      end else begin
        heading_d = heading_q - step;
        dir_d     = DIR_NEG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      heading_q   <= '0;
    end else if (out_ready) begin
      out_valid_q <= brg_valid_q;
      if (brg_valid_q) begin
        heading_q <= heading_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && brg_valid_q) begin
      out_q.heading  <= heading_d;
      out_q.bearing  <= brg_q;
      out_q.turn_dir <= dir_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

// ----- src/heading_follower_slew_limited.sv -----
`timescale 1ns / 1ps
// Top level of the slew-limited heading follower: CORDIC atan2 pipeline plus heading update.
// Depends on hfsl_pkg, hfsl_stream_if and the hfsl_* submodules.
//
//  channel | dir | payload                           | transaction
//  --------+-----+-----------------------------------+---------------------------
//  cfg_i   | in  | index, data                       | register write
//  in_i    | in  | target_x, target_y, elapsed_us    | one target sample
//  out_o   | out | heading, bearing, turn_dir        | one result per sample
//
// One sample enters per cycle while out_o is not stalled; the path runs through the input
// register, one registered stage per CORDIC iteration, bearing rounding and the output register.
// The heading feedback closes within the output stage, so back-to-back samples
// see each other's heading. Each stage holds its contents while the next is full,
// so a stall on out_o fills the pipeline before in_i.ready drops.
// Reset clears all valid bits and the heading and reloads the register defaults.

module heading_follower_slew_limited #(
  parameter int unsigned CordicSteps = hfsl_pkg::CORDIC_STEPS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hfsl_stream_if.sink   cfg_i,
  hfsl_stream_if.sink   in_i,
  hfsl_stream_if.source out_o
);
  import hfsl_pkg::*;

  localparam int unsigned NumStages = (CordicSteps > ATAN_LEN) ? ATAN_LEN : CordicSteps;

  cfg_regs_t regs;
  cordic_t   stage_data  [NumStages+1];
  logic      stage_valid [NumStages+1];
  logic      stage_ready [NumStages+1];

  hfsl_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  hfsl_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (regs),
    .ready_next_i (stage_ready[0]),
    .valid_o      (stage_valid[0]),
    .data_o       (stage_data[0])
  );

  // One registered iteration per stage
  for (genvar k = 0; k < NumStages; k++) begin : g_iter
    hfsl_cordic_stage #(
      .StageIdx (k)
    ) u_stage (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .valid_i      (stage_valid[k]),
      .data_i       (stage_data[k]),
      .ready_o      (stage_ready[k]),
      .ready_next_i (stage_ready[k+1]),
      .valid_o      (stage_valid[k+1]),
      .data_o       (stage_data[k+1])
    );
  end

  hfsl_heading u_heading (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid[NumStages]),
    .data_i  (stage_data[NumStages]),
    .ready_o (stage_ready[NumStages]),
    .out_o   (out_o)
  );

endmodule

// ----- src/hfsl_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the result channel of the heading follower, bound to the top level.
// Depends on hfsl_pkg; attaches to heading_follower_slew_limited.

module hfsl_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [hfsl_pkg::AngleW-1:0] out_heading,
  input logic [hfsl_pkg::AngleW-1:0] out_bearing,
  input logic [1:0]                out_dir
);
  import hfsl_pkg::*;

  // Heading of the last delivered result (reset heading is zero)
  logic [AngleW-1:0] last_heading_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_heading_q <= '0;
    end else if (out_valid && out_ready) begin
      last_heading_q <= out_heading;
    end
  end

  // No result is presented while in reset
  a_idle_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("result valid during reset");

  // A stalled result keeps its contents
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_heading) && $stable(out_bearing) && $stable(out_dir)))
    else $error("stalled result changed");

  // No turn reported means the heading carried over from the previous result
  a_no_turn_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_dir == DIR_NONE) |-> (out_heading == last_heading_q))
    else $error("heading moved without a turn");

  // A reported turn always moves the heading
  a_turn_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && (out_dir == DIR_POS || out_dir == DIR_NEG)) |->
      (out_heading != last_heading_q))
    else $error("turn reported but heading unchanged");

endmodule

bind heading_follower_slew_limited hfsl_checker u_hfsl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_heading (out_o.payload.heading),
  .out_bearing (out_o.payload.bearing),
  .out_dir     (out_o.payload.turn_dir)
);
